// File: rtl/rbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative bearing package
// Shared constants, CORDIC arctangent table and the per-cell state type.
// ----------------------------------------------------------------------------
package rbt_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int HEADING_FRAC    = 7;
  localparam int TABLE_FRAC      = 16;

  // CORDIC datapath width: |x|,|y| stay below 2^50
  localparam int CW   = 52;
  // angle width, signed, holds +-360 deg
  localparam int ZW   = ANGLE_FRAC_BITS + 11;
  localparam int IDXW = 5;

  localparam int HSHL = (ANGLE_FRAC_BITS >= HEADING_FRAC) ? ANGLE_FRAC_BITS - HEADING_FRAC : 0;
  localparam int HSHR = (ANGLE_FRAC_BITS < HEADING_FRAC) ? HEADING_FRAC - ANGLE_FRAC_BITS : 0;
  localparam int HW   = 16 + HSHL;
  localparam int BW   = ((HW > ZW) ? HW : ZW) + 2;

  localparam int TSH  = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int TRND = (TSH > 0) ? (1 << (TSH - 1)) : 0;

  localparam int LAT  = CORDIC_STAGES + 4;

  localparam logic signed [ZW-1:0] ANG_QTR  = ZW'(90)  <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] ANG_HALF = ZW'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] ANG_3QTR = ZW'(270) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] ANG_FULL = ZW'(360) <<< ANGLE_FRAC_BITS;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [21:0] ATAN_TABLE [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 spec;
    logic signed [ZW-1:0] spec_ang;
    logic [HW-1:0]        hu;
  } cell_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [IDXW-1:0] idx);
    logic [22:0]   t;
    logic [ZW-1:0] r;
    t = {1'b0, ATAN_TABLE[idx]} + 23'(TRND);
    r = ZW'(t >> TSH);
    return signed'(r);
  endfunction

endpackage

// File: rtl/rbt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative bearing channels
// Request channel (positions, heading) and result channel (bearing).
// ----------------------------------------------------------------------------
interface rbt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] from_x;
  logic signed [31:0] from_y;
  logic signed [31:0] to_x;
  logic signed [31:0] to_y;
  logic [15:0]        heading;

  modport source (output valid, from_x, from_y, to_x, to_y, heading, input ready);
  modport sink   (input valid, from_x, from_y, to_x, to_y, heading, output ready);
endinterface

interface rbt_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] bearing;

  modport source (output valid, bearing, input ready);
  modport sink   (input valid, bearing, output ready);
endinterface

// File: rtl/relative_bearing_to_target.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative bearing to target
// Throughput: one request per cycle; a stalled result freezes the whole pipe.
// Depth is set by the row of CORDIC cells plus input and three post stages.
// Reset clears the valid pipeline and sets axis_tolerance to 0.
// ----------------------------------------------------------------------------
module relative_bearing_to_target
  import rbt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  rbt_in_if.sink      req_i,
  rbt_out_if.source   rsp_o
);

  logic [15:0]          tol_q;
  logic                 en;
  logic [LAT-1:0]       valid_q;

  logic signed [32:0]   dx_d, dy_d, dx_q, dy_q;
  logic [HW-1:0]        hu_d, hu_q;
  logic signed [32:0]   adx, ady, tol_s;
  logic signed [CW-1:0] xi, yi;
  cell_t                head;
  cell_t                chain [CORDIC_STAGES+1];

  assign en          = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], req_i.valid};
    end
  end

  // input stage
  always_comb begin
    dx_d = 33'(req_i.to_x) - 33'(req_i.from_x);
    dy_d = 33'(req_i.to_y) - 33'(req_i.from_y);
    hu_d = (HW'(req_i.heading) << HSHL) >> HSHR;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      hu_q <= hu_d;
    end
  end

  // axis checks and quadrant pre-rotation into the first cell
  always_comb begin
    adx   = (dx_q < 0) ? -dx_q : dx_q;
    ady   = (dy_q < 0) ? -dy_q : dy_q;
    tol_s = signed'({17'd0, tol_q});
    xi    = -(CW'(dy_q) <<< 16);
    yi    = CW'(dx_q) <<< 16;

    head    = '0;
    head.hu = hu_q;
    if (xi < 0) begin
      if (yi >= 0) begin
        head.x = yi;
        head.y = -xi;
        head.z = ANG_QTR;
      end else begin
        head.x = -yi;
        head.y = xi;
        head.z = -ANG_QTR;
      end
    end else begin
      head.x = xi;
      head.y = yi;
      head.z = '0;
    end

    if (ady <= tol_s) begin
      head.spec     = 1'b1;
      head.spec_ang = (dx_q > 0) ? ANG_QTR : ((dx_q < 0) ? ANG_3QTR : '0);
    end else if (adx <= tol_s) begin
      head.spec     = 1'b1;
      head.spec_ang = (dy_q > 0) ? ANG_HALF : '0;
    end else begin
      head.spec     = 1'b0;
      head.spec_ang = '0;
    end
  end

  assign chain[0] = head;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    rbt_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .idx_i  (IDXW'(k)),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  rbt_post u_post (
    .clk_i     (clk_i),
    .en_i      (en),
    .cell_i    (chain[CORDIC_STAGES]),
    .bearing_o (rsp_o.bearing)
  );

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.bearing >= -9'sd179 && rsp_o.bearing <= 9'sd180))
    else $error("bearing out of range");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && !cfg_we_i) |=> $stable(valid_q))
    else $error("pipeline moved during stall");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && valid_q[LAT-2]) |=> rsp_o.valid)
    else $error("request lost before output");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> valid_q[0])
    else $error("accepted request not in pipeline");

endmodule

// File: rtl/rbt_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward y = 0; side data passes through.
// ----------------------------------------------------------------------------
module rbt_cordic_cell
  import rbt_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [IDXW-1:0] idx_i,
  input  cell_t           cell_i,
  output cell_t           cell_o
);

  cell_t                cell_d, cell_q;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;

  always_comb begin
    xs     = cell_i.x >>> idx_i;
    ys     = cell_i.y >>> idx_i;
    ang    = atan_entry(idx_i);
    cell_d = cell_i;
    if (cell_i.y > 0) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + ang;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/rbt_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bearing post-processing
// Angle select and wrap, heading subtract, reduction and rounding.
// ----------------------------------------------------------------------------
module rbt_post
  import rbt_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  cell_t             cell_i,
  output logic signed [8:0] bearing_o
);

  localparam logic signed [BW-1:0] FULL_B = BW'(ANG_FULL);
  localparam logic signed [BW-1:0] HALF_B = BW'(ANG_HALF);
  localparam logic [ANGLE_FRAC_BITS-1:0] HALF_FRAC = ANGLE_FRAC_BITS'(1) << (ANGLE_FRAC_BITS - 1);

  logic signed [ZW-1:0] zw, ang;
  logic signed [BW-1:0] diff_d, diff_q;
  logic signed [BW-1:0] b0, b1, b_d, b_q;
  logic signed [BW-1:0] mag;
  logic [8:0]           whole;
  logic signed [8:0]    res, bearing_d, bearing_q;

  // stage 1: angle in [0,360), minus heading
  always_comb begin
    zw = cell_i.z;
    if (zw < 0) begin
      zw = zw + ANG_FULL;
    end
    if (zw >= ANG_FULL) begin
      zw = zw - ANG_FULL;
    end
    ang    = cell_i.spec ? cell_i.spec_ang : zw;
    diff_d = BW'(ang) - signed'(BW'(cell_i.hu));
  end

  // stage 2: heading is below 720 deg, two corrections reach [0,360), then fold to (-180,180]
  always_comb begin
    b0  = (diff_q < 0) ? diff_q + FULL_B : diff_q;
    b1  = (b0 < 0) ? b0 + FULL_B : b0;
    b_d = (b1 > HALF_B) ? b1 - FULL_B : b1;
  end

  // stage 3: round half toward zero, -180 reads as 180
  always_comb begin
    mag   = (b_q < 0) ? -b_q : b_q;
    whole = 9'(mag >>> ANGLE_FRAC_BITS);
    if (mag[ANGLE_FRAC_BITS-1:0] > HALF_FRAC) begin
      whole = whole + 9'd1;
    end
    res       = (b_q < 0) ? -signed'(whole) : signed'(whole);
    bearing_d = (res <= -9'sd180) ? 9'sd180 : res;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q    <= diff_d;
      b_q       <= b_d;
      bearing_q <= bearing_d;
    end
  end

  assign bearing_o = bearing_q;

endmodule

// File: dv/tb_relative_bearing_to_target.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative bearing to target testbench
// Sends observer/target positions and headings through the request channel,
// predicts each bearing with a CORDIC vectoring model at block widths, and
// checks results in order. Covers axis tolerance settings from 0 to 65535,
// axis and rounding corner cases, random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_relative_bearing_to_target;
  import rbt_pkg::*;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic [15:0]        hdg;
  } bearing_req_t;

  localparam longint ATAN_DEG_Q16 [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };
  localparam longint DEG  = longint'(1) << ANGLE_FRAC_BITS;
  localparam longint FULL = 360 * DEG;
  localparam longint HALF = 180 * DEG;
  localparam int     REQS_PER_PHASE = 235;

  class bearing_scoreboard;
    logic signed [8:0] expected_bearings[$];
    longint axis_tol;
    int     errors;
    int     reported;

    function new();
      axis_tol = 0;
      errors   = 0;
      reported = 0;
    endfunction

    function automatic longint atan_units(int i);
      int sh;
      sh = TABLE_FRAC - ANGLE_FRAC_BITS;
      if (sh == 0) begin
        return ATAN_DEG_Q16[i];
      end
      return (ATAN_DEG_Q16[i] + (longint'(1) << (sh - 1))) >> sh;
    endfunction

    function automatic longint cordic_angle(longint dx, longint dy);
      longint x, y, z, xs, ys, t;
      x = -dy * 65536;
      y = dx * 65536;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = 90 * DEG;
        end else begin
          x = -y;
          y = t;
          z = -90 * DEG;
        end
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        ys = y >>> (i % 32);
        xs = x >>> (i % 32);
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_units(i % 32);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_units(i % 32);
        end
      end
      if (z < 0) z = z + FULL;
      if (z >= FULL) z = z - FULL;
      return z;
    endfunction

    function automatic logic signed [8:0] predict_bearing(bearing_req_t r);
      longint dx, dy, adx, ady, angle, hu, b, mag, whole, fr, res;
      dx  = longint'(r.tx) - longint'(r.fx);
      dy  = longint'(r.ty) - longint'(r.fy);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      if (ady <= axis_tol) begin
        angle = (dx > 0) ? 90 * DEG : ((dx < 0) ? 270 * DEG : 0);
      end else if (adx <= axis_tol) begin
        angle = (dy > 0) ? HALF : 0;
      end else begin
        angle = cordic_angle(dx, dy);
      end
      if (ANGLE_FRAC_BITS >= HEADING_FRAC) begin
        hu = longint'(r.hdg) << HSHL;
      end else begin
        hu = longint'(r.hdg) >> HSHR;
      end
      b = (angle - hu) % FULL;
      if (b < 0) b = b + FULL;
      if (b > HALF) b = b - FULL;
      mag   = (b < 0) ? -b : b;
      whole = mag >> ANGLE_FRAC_BITS;
      fr    = mag & (DEG - 1);
      if (fr > (DEG >> 1)) whole = whole + 1;
      res = (b < 0) ? -whole : whole;
      if (res <= -180) res = 180;
      return res[8:0];
    endfunction

    function void note_request(bearing_req_t r);
      expected_bearings.push_back(predict_bearing(r));
    endfunction

    function void check_bearing(logic signed [8:0] got);
      logic signed [8:0] want;
      if (expected_bearings.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: unexpected bearing %0d", got);
        end
        return;
      end
      want = expected_bearings.pop_front();
      if (got !== want) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: bearing mismatch, expected %0d actual %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_bearings.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        steady;

  rbt_in_if  req_if ();
  rbt_out_if rsp_if ();

  bearing_scoreboard sb;

  relative_bearing_to_target dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_if.ready <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request('{req_if.from_x, req_if.from_y, req_if.to_x, req_if.to_y,
                          req_if.heading});
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_bearing(rsp_if.bearing);
      end
    end
  end

  function automatic bearing_req_t make_req(logic signed [31:0] fx, logic signed [31:0] fy,
                                            logic signed [31:0] tx, logic signed [31:0] ty,
                                            logic [15:0] hdg);
    bearing_req_t r;
    r.fx  = fx;
    r.fy  = fy;
    r.tx  = tx;
    r.ty  = ty;
    r.hdg = hdg;
    return r;
  endfunction

  function automatic logic signed [31:0] edge_coord();
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic bearing_req_t random_req(longint tol);
    bearing_req_t r;
    int           near;
    int           t;
    t      = int'(tol);
    near   = int'($urandom_range(0, 2 * t + 4)) - (t + 2);
    r.hdg  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46079));
    r.fx   = $signed($urandom) >>> 2;
    r.fy   = $signed($urandom) >>> 2;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        r.fx = $urandom;
        r.fy = $urandom;
        r.tx = $urandom;
        r.ty = $urandom;
      end
      3, 4: begin
        r.tx = r.fx + ($signed($urandom) >>> $urandom_range(11, 30));
        r.ty = r.fy + ($signed($urandom) >>> $urandom_range(11, 30));
      end
      5, 6: begin
        r.tx = r.fx + ($signed($urandom) >>> $urandom_range(2, 24));
        r.ty = r.fy + near;
      end
      7: begin
        r.tx = r.fx + near;
        r.ty = r.fy + ($signed($urandom) >>> $urandom_range(2, 24));
      end
      8: begin
        r.tx = $urandom_range(0, 1) ? r.fx : r.fx + ($signed($urandom) >>> 2);
        r.ty = $urandom_range(0, 1) ? r.fy : r.fy + ($signed($urandom) >>> 2);
      end
      default: begin
        r.fx = edge_coord();
        r.fy = edge_coord();
        r.tx = edge_coord();
        r.ty = edge_coord();
      end
    endcase
    return r;
  endfunction

  task automatic send_req(bearing_req_t r);
    if (!steady) begin
      while ($urandom_range(0, 99) < 27) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid   <= 1'b1;
    req_if.from_x  <= r.fx;
    req_if.from_y  <= r.fy;
    req_if.to_x    <= r.tx;
    req_if.to_y    <= r.ty;
    req_if.heading <= r.hdg;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.axis_tol = v;
  endtask

  task automatic run_random(logic [15:0] tol, logic no_idle);
    drain();
    write_tolerance(tol);
    steady = no_idle;
    repeat (REQS_PER_PHASE) send_req(random_req(sb.axis_tol));
    steady = 1'b0;
  endtask

  initial begin
    sb             = new();
    steady         = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.from_x  = '0;
    req_if.from_y  = '0;
    req_if.to_x    = '0;
    req_if.to_y    = '0;
    req_if.heading = '0;
    rsp_if.ready   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_tolerance(16'd0);

    // axis hits, diagonals, coordinate extremes, heading wrap and rounding
    send_req(make_req(0, 0, 1000, 0, 16'd0));
    send_req(make_req(0, 0, -1000, 0, 16'd0));
    send_req(make_req(5, 7, 5, 7, 16'd0));
    send_req(make_req(0, 0, 0, 1000, 16'd0));
    send_req(make_req(0, 0, 0, -1000, 16'd0));
    send_req(make_req(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'd0));
    send_req(make_req(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0));
    send_req(make_req(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 1, 16'd0));
    send_req(make_req(0, 0, 1, -1, 16'd0));
    send_req(make_req(0, 0, -1, 1, 16'd0));
    send_req(make_req(0, 0, -1, -1, 16'd0));
    send_req(make_req(0, 0, 0, 0, 16'd46079));
    send_req(make_req(0, 0, 1000, 0, 16'hFFFF));
    send_req(make_req(0, 0, 0, 0, 16'd46080));
    send_req(make_req(0, 0, 1000, 0, 16'd64));
    send_req(make_req(0, 0, 0, 0, 16'd64));
    send_req(make_req(0, 0, 0, 0, 16'd192));
    send_req(make_req(0, 0, 0, 0, 16'd22989));
    send_req(make_req(0, 0, 0, 5, 16'd0));
    send_req(make_req(-1, -1, -1, -1, 16'hFFFF));
    send_req(make_req(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                      16'h5555));
    send_req(make_req(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA,
                      16'hAAAA));
    repeat (REQS_PER_PHASE) send_req(random_req(sb.axis_tol));

    run_random(16'hFFFF, 1'b0);
    run_random(16'd1, 1'b1);
    run_random(16'($urandom_range(2, 65534)), 1'b0);
    run_random(16'h8000, 1'b0);
    run_random(16'd0, 1'b0);

    drain();
    repeat (LAT + 4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("ERROR: %0d bearings never arrived", sb.pending());
      sb.errors += sb.pending();
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ERROR: timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
rtl/rbt_pkg.sv
rtl/rbt_if.sv
rtl/rbt_cordic_cell.sv
rtl/rbt_post.sv
rtl/relative_bearing_to_target.sv
dv/tb_relative_bearing_to_target.sv
